### hw/rtl/lld_pkg.sv
// shared types and constants for the least-loaded range dispatcher
// no dependencies; compiled first

package lld_pkg;

  localparam int ELEVATORS_DEF = 8;
  localparam int LOAD_BITS_DEF = 16;

  localparam int FLOOR_W    = 8;
  localparam int IDX_W      = 3;
  localparam int TIE_W      = 4;
  localparam int MAX_TIED   = 8;
  localparam int ROT_W      = 32;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOWEST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHEST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 2'd2;

  typedef enum logic {
    MODE_SCAN,
    MODE_SELECT
  } lld_mode_e;

  // token handed from cell to cell
  typedef struct packed {
    logic                  vld;
    lld_mode_e             mode;
    logic                  any;
    logic [TIE_W-1:0]      ntied;
    logic [IDX_W-1:0]      k;
    logic                  hit;
    logic [IDX_W-1:0]      win;
  } lld_rec_t;

endpackage

### hw/rtl/lld_if.sv
// request and result channel interfaces
// depends on lld_pkg

interface lld_req_if;
  import lld_pkg::*;

  logic               valid;
  logic               ready;
  logic [FLOOR_W-1:0] board_floor;
  logic [FLOOR_W-1:0] exit_floor;

  modport source (output valid, output board_floor, output exit_floor, input ready);
  modport sink   (input valid, input board_floor, input exit_floor, output ready);
endinterface

interface lld_rsp_if;
  import lld_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] chosen_elevator;

  modport source (output valid, output found, output chosen_elevator, input ready);
  modport sink   (input valid, input found, input chosen_elevator, output ready);
endinterface

### hw/rtl/lld_cell.sv
// one elevator cell: holds its load count, checks range, updates the token
// depends on lld_pkg

module lld_cell #(
  parameter int LOAD_BITS = lld_pkg::LOAD_BITS_DEF,
  parameter int IDX       = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [lld_pkg::FLOOR_W-1:0] lo_i,
  input  logic [lld_pkg::FLOOR_W-1:0] hi_i,
  input  logic [lld_pkg::FLOOR_W-1:0] start_i,
  input  logic [lld_pkg::FLOOR_W-1:0] end_i,
  input  lld_pkg::lld_rec_t         rec_i,
  input  logic [LOAD_BITS-1:0]      min_i,
  output lld_pkg::lld_rec_t         rec_o,
  output logic [LOAD_BITS-1:0]      min_o
);
  import lld_pkg::*;

  localparam logic [LOAD_BITS-1:0] LoadMax = '1;

  lld_rec_t             rec_d, rec_q;
  logic [LOAD_BITS-1:0] min_d, min_q;
  logic [LOAD_BITS-1:0] load_d, load_q;
  logic                 elig;

  assign elig = en_i && (start_i >= lo_i) && (start_i <= hi_i)
                && (end_i >= lo_i) && (end_i <= hi_i);

  always_comb begin
    rec_d  = rec_i;
    min_d  = min_i;
    load_d = load_q;
    if (rec_i.vld && elig) begin
      case (rec_i.mode)
        MODE_SCAN: begin
          if (!rec_i.any || (load_q < min_i)) begin
            rec_d.any   = 1'b1;
            rec_d.ntied = TIE_W'(1);
            min_d       = load_q;
          end else if (load_q == min_i) begin
            rec_d.ntied = rec_i.ntied + TIE_W'(1);
          end
        end
        MODE_SELECT: begin
          if (!rec_i.hit && (load_q == min_i)) begin
            if (rec_i.k == '0) begin
              rec_d.hit = 1'b1;
              rec_d.win = IDX_W'(IDX);
              if (load_q != LoadMax) begin
                load_d = load_q + LOAD_BITS'(1);
              end
            end else begin
              rec_d.k = rec_i.k - IDX_W'(1);
            end
          end
        end
        default: begin
          rec_d = rec_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q  <= '0;
      load_q <= '0;
    end else begin
      rec_q  <= rec_d;
      load_q <= load_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
  end

  assign rec_o = rec_q;
  assign min_o = min_q;

endmodule

### hw/rtl/least_loaded_range_dispatch.sv
// least-loaded range dispatcher, top level
// depends on lld_pkg, lld_req_if, lld_rsp_if and lld_cell
//
// - req_i carries one passenger request word (boarding and leaving floor); rsp_o returns
//   one result word per request: found and the chosen elevator (0 when nothing fits)
// - configuration: write enable, register index (0 lowest floors, 1 highest floors,
//   2 elevator count) and 64-bit data; writes to index 3 are dropped; write only idle
// - a row of ELEVATORS cells, one per elevator, each holding its load count; a token
//   walks down the row one cell per cycle in two passes: the first finds the least
//   load and how many eligible elevators share it, the second picks the tied elevator
//   given by the rotation count and bumps its load
// - the rotation modulo comes from small residue counters, one per possible tie size
// - a request runs the scan pass, then the select pass when an elevator is found, then
//   the result state, from which the result word moves into the output register; a
//   new request is taken only once the sequencer is back in idle after that
// - the output register lets the next request be taken while a result still waits;
//   a second result waits in the sequencer until the receiver takes the first
// - reset clears all loads, the rotation count and the floor ranges, and sets the
//   elevator count to one

module least_loaded_range_dispatch #(
  parameter int ELEVATORS = lld_pkg::ELEVATORS_DEF,
  parameter int LOAD_BITS = lld_pkg::LOAD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lld_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lld_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lld_req_if.sink                       req_i,
  lld_rsp_if.source                     rsp_o
);
  import lld_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SELECT,
    ST_RESULT
  } state_e;

  // configuration registers
  logic [CFG_DATA_W-1:0] lowest_q;
  logic [CFG_DATA_W-1:0] highest_q;
  logic [COUNT_W-1:0]    count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_q  <= '0;
      highest_q <= '0;
      count_q   <= COUNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOWEST:  lowest_q  <= cfg_data_i;
        REG_HIGHEST: highest_q <= cfg_data_i;
        REG_COUNT:   count_q   <= cfg_data_i[COUNT_W-1:0];
        default:     ;
      endcase
    end
  end

  // sequencer state
  state_e               state_q;
  logic [FLOOR_W-1:0]   start_q, end_q;
  lld_rec_t             seed_q;
  logic [LOAD_BITS-1:0] seed_min_q;
  logic                 res_found_q;
  logic [IDX_W-1:0]     res_win_q;
  logic                 rsp_vld_q;
  logic                 rsp_found_q;
  logic [IDX_W-1:0]     rsp_win_q;
  logic [ROT_W-1:0]     rot_q;
  logic [IDX_W-1:0]     res_q [MAX_TIED];

  // cell row
  lld_rec_t             rec_chain [ELEVATORS+1];
  logic [LOAD_BITS-1:0] min_chain [ELEVATORS+1];
  lld_rec_t             tail;
  logic [IDX_W-1:0]     pick;

  // tokens that start each pass
  lld_rec_t             scan_seed;
  lld_rec_t             select_seed;
  logic                 rsp_load;

  assign rec_chain[0] = seed_q;
  assign min_chain[0] = seed_min_q;
  assign tail         = rec_chain[ELEVATORS];

  for (genvar i = 0; i < ELEVATORS; i++) begin : g_cell
    lld_cell #(
      .LOAD_BITS (LOAD_BITS),
      .IDX       (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (COUNT_W'(i) < count_q),
      .lo_i    (lowest_q[FLOOR_W*i +: FLOOR_W]),
      .hi_i    (highest_q[FLOOR_W*i +: FLOOR_W]),
      .start_i (start_q),
      .end_i   (end_q),
      .rec_i   (rec_chain[i]),
      .min_i   (min_chain[i]),
      .rec_o   (rec_chain[i+1]),
      .min_o   (min_chain[i+1])
    );
  end

  // rotation count modulo the tie size
  assign pick = res_q[IDX_W'(tail.ntied - TIE_W'(1))];

  always_comb begin
    scan_seed         = '0;
    scan_seed.vld     = 1'b1;
    scan_seed.mode    = MODE_SCAN;
    select_seed       = '0;
    select_seed.vld   = 1'b1;
    select_seed.mode  = MODE_SELECT;
    select_seed.any   = 1'b1;
    select_seed.ntied = tail.ntied;
    select_seed.k     = pick;
  end

  // finished result moves into the output register when that is free or being taken
  assign rsp_load = (state_q == ST_RESULT) && (!rsp_vld_q || rsp_o.ready);

  assign req_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      seed_q    <= '0;
      rsp_vld_q <= 1'b0;
      rot_q     <= '0;
      for (int n = 0; n < MAX_TIED; n++) begin
        res_q[n] <= '0;
      end
    end else begin
      if (rsp_vld_q && rsp_o.ready && !rsp_load) begin
        rsp_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            start_q <= req_i.board_floor;
            end_q   <= req_i.exit_floor;
            seed_q  <= scan_seed;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tail.vld && tail.any) begin
            seed_q     <= select_seed;
            seed_min_q <= min_chain[ELEVATORS];
            state_q    <= ST_SELECT;
          end else begin
            seed_q.vld <= 1'b0;
            if (tail.vld) begin
              res_found_q <= 1'b0;
              res_win_q   <= '0;
              state_q     <= ST_RESULT;
            end
          end
        end
        ST_SELECT: begin
          seed_q.vld <= 1'b0;
          if (tail.vld) begin
            res_found_q <= 1'b1;
            res_win_q   <= tail.win;
            rot_q       <= rot_q + ROT_W'(1);
            // residue n-1 tracks the rotation count modulo n; all clear on wrap
            for (int n = 0; n < MAX_TIED; n++) begin
              if ((rot_q == '1) || (res_q[n] == IDX_W'(n))) begin
                res_q[n] <= '0;
              end else begin
                res_q[n] <= res_q[n] + IDX_W'(1);
              end
            end
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (rsp_load) begin
            rsp_vld_q   <= 1'b1;
            rsp_found_q <= res_found_q;
            rsp_win_q   <= res_win_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid           = rsp_vld_q;
  assign rsp_o.found           = rsp_found_q;
  assign rsp_o.chosen_elevator = rsp_win_q;

endmodule

### bench/lld_dispatch_check.sv
// watches the request, result and configuration ports of the dispatcher,
// predicts each result word and compares it; depends on lld_pkg and lld_if
`timescale 1ns / 100ps

module lld_dispatch_check #(
  parameter int ELEVATORS = lld_pkg::ELEVATORS_DEF,
  parameter int LOAD_BITS = lld_pkg::LOAD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lld_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lld_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lld_req_if                             req_i,
  lld_rsp_if                             rsp_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    pending_o
);
  import lld_pkg::*;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] elevator;
  } dispatch_word_t;

  // shadow of the block's registers and state
  logic [CFG_DATA_W-1:0] lowest_q;
  logic [CFG_DATA_W-1:0] highest_q;
  logic [COUNT_W-1:0]    cars_in_use;
  logic [LOAD_BITS-1:0]  loads [ELEVATORS];
  logic [ROT_W-1:0]      rotation;

  dispatch_word_t expected_words [$];
  dispatch_word_t want;
  int unsigned    mismatches;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string what);
    $display("[%0t] dispatch mismatch: %s", $time, what);
    mismatches++;
  endtask

  // least load among the cars covering both floors, rotation picks among ties
  function automatic dispatch_word_t predict_assignment(logic [FLOOR_W-1:0] s,
                                                        logic [FLOOR_W-1:0] e);
    dispatch_word_t       res;
    logic [ELEVATORS-1:0] eligible;
    logic [LOAD_BITS-1:0] least;
    logic [FLOOR_W-1:0]   lo;
    logic [FLOOR_W-1:0]   hi;
    logic                 any;
    int unsigned          active;
    int unsigned          ntied;
    int unsigned          winner;
    int unsigned          tied [ELEVATORS];
    res      = '0;
    eligible = '0;
    least    = '0;
    any      = 1'b0;
    ntied    = 0;
    active   = (cars_in_use > ELEVATORS) ? ELEVATORS : cars_in_use;
    for (int unsigned i = 0; i < ELEVATORS; i++) begin
      lo = lowest_q[FLOOR_W*i +: FLOOR_W];
      hi = highest_q[FLOOR_W*i +: FLOOR_W];
      eligible[i] = (i < active) && s >= lo && s <= hi && e >= lo && e <= hi;
      if (eligible[i] && (!any || loads[i] < least)) begin
        least = loads[i];
        any   = 1'b1;
      end
    end
    if (any) begin
      for (int unsigned i = 0; i < ELEVATORS; i++) begin
        if (eligible[i] && loads[i] == least) begin
          tied[ntied] = i;
          ntied++;
        end
      end
      winner       = tied[rotation % ntied];
      res.found    = 1'b1;
      res.elevator = IDX_W'(winner);
      rotation     = rotation + 1'b1;
      if (loads[winner] != '1) loads[winner] = loads[winner] + 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_q    = '0;
      highest_q   = '0;
      cars_in_use = COUNT_W'(1);
      rotation    = '0;
      for (int i = 0; i < ELEVATORS; i++) loads[i] = '0;
      expected_words.delete();
      mismatches  = 0;
      pending_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LOWEST:  lowest_q    = cfg_data_i;
          REG_HIGHEST: highest_q   = cfg_data_i;
          REG_COUNT:   cars_in_use = cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end
      // result side first: a word leaving now belongs to an older request
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word found=%0b elevator=%0d",
                                    rsp_i.found, rsp_i.chosen_elevator));
        end else begin
          want = expected_words.pop_front();
          if (rsp_i.found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", rsp_i.found, want.found));
          if (rsp_i.chosen_elevator !== want.elevator)
            report_mismatch($sformatf("elevator %0d, expected %0d",
                                      rsp_i.chosen_elevator, want.elevator));
        end
      end
      if (req_i.valid && req_i.ready)
        expected_words.push_back(predict_assignment(req_i.board_floor, req_i.exit_floor));
      pending_o <= expected_words.size();
    end
  end

endmodule

### bench/least_loaded_range_dispatch_tb.sv
// top of the dispatcher testbench: clock, reset, register writes, request
// stimulus and result back-pressure; depends on lld_pkg, lld_if and lld_dispatch_check
`timescale 1ns / 100ps

module least_loaded_range_dispatch_tb;
  import lld_pkg::*;

  localparam int ELEVATORS      = ELEVATORS_DEF;
  localparam int LOAD_BITS      = LOAD_BITS_DEF;
  // acceptance to result register when an elevator is found
  localparam int LATENCY        = 2*ELEVATORS + 3;
  // cycles without any word moving before the run is called hung
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_WORDS    = 110;

  // index with no register behind it, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned mismatch_count;
  int unsigned pending_words;
  int unsigned quiet_cycles;
  logic        back_to_back;

  // what the stimulus last programmed, used only to aim floors at real ranges
  logic [CFG_DATA_W-1:0] tb_lowest;
  logic [CFG_DATA_W-1:0] tb_highest;
  logic [COUNT_W-1:0]    tb_count;

  lld_req_if req_if ();
  lld_rsp_if rsp_if ();

  least_loaded_range_dispatch #(
    .ELEVATORS (ELEVATORS),
    .LOAD_BITS (LOAD_BITS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  lld_dispatch_check #(
    .ELEVATORS (ELEVATORS),
    .LOAD_BITS (LOAD_BITS)
  ) u_dispatch_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle lengths: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // one request word; valid stays high into the next call when no gap is drawn
  task automatic push_request(input logic [FLOOR_W-1:0] s, input logic [FLOOR_W-1:0] e);
    int unsigned gap;
    gap = back_to_back ? 0 : pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.board_floor <= s;
    req_if.exit_floor  <= e;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // hold off the sender until every predicted word has come back;
  // the count from the checker is registered, hence the leading wait
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  // back-to-back register writes, spare index last, only while the block is idle
  task automatic program_registers(input logic [CFG_DATA_W-1:0] lo,
                                   input logic [CFG_DATA_W-1:0] hi,
                                   input logic [CFG_DATA_W-1:0] count_word);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_LOWEST;
    cfg_data <= lo;
    @(posedge clk);
    cfg_idx  <= REG_HIGHEST;
    cfg_data <= hi;
    @(posedge clk);
    cfg_idx  <= REG_COUNT;
    cfg_data <= count_word;
    @(posedge clk);
    cfg_idx  <= REG_SPARE;
    cfg_data <= {32'($urandom), 32'($urandom)};
    @(posedge clk);
    cfg_we   <= 1'b0;
    tb_lowest  = lo;
    tb_highest = hi;
    tb_count   = count_word[COUNT_W-1:0];
  endtask

  // random layout of ranges and car count, weighted towards useful shapes
  task automatic choose_layout();
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [COUNT_W-1:0]    n;
    int unsigned           kind;
    int unsigned           r;
    kind = $urandom_range(0, 3);
    for (int i = 0; i < 8; i++) begin
      case (kind)
        0: begin
          // ranges that all span the middle, plenty of overlap
          lo[8*i +: 8] = 8'($urandom_range(0, 127));
          hi[8*i +: 8] = 8'($urandom_range(128, 255));
        end
        1: begin
          // every car serves every floor, ties all the time
          lo[8*i +: 8] = 8'h00;
          hi[8*i +: 8] = 8'hFF;
        end
        2: begin
          // anything goes, empty ranges included
          lo[8*i +: 8] = 8'($urandom);
          hi[8*i +: 8] = 8'($urandom);
        end
        default: begin
          // disjoint bands shared by pairs of cars
          lo[8*i +: 8] = 8'((i / 2) * 64);
          hi[8*i +: 8] = 8'((i / 2) * 64 + 63);
        end
      endcase
    end
    r = $urandom_range(0, 99);
    if (r < 5)       n = '0;
    else if (r < 20) n = COUNT_W'(8);
    else if (r < 30) n = COUNT_W'($urandom_range(9, 15));
    else             n = COUNT_W'($urandom_range(1, 8));
    // upper data bits are junk the count register must ignore
    program_registers(lo, hi, {32'($urandom), 28'($urandom), n});
  endtask

  // mostly floors inside some active car's range, some extremes, some noise
  task automatic pick_floors(output logic [FLOOR_W-1:0] s, output logic [FLOOR_W-1:0] e);
    int unsigned        active;
    int unsigned        j;
    int unsigned        r;
    logic [FLOOR_W-1:0] lo;
    logic [FLOOR_W-1:0] hi;
    active = (tb_count > ELEVATORS) ? ELEVATORS : tb_count;
    r = $urandom_range(0, 99);
    s = FLOOR_W'($urandom);
    e = FLOOR_W'($urandom);
    if (r < 70 && active != 0) begin
      j  = $urandom_range(0, active - 1);
      lo = tb_lowest[FLOOR_W*j +: FLOOR_W];
      hi = tb_highest[FLOOR_W*j +: FLOOR_W];
      if (lo <= hi) begin
        s = FLOOR_W'($urandom_range(hi, lo));
        e = FLOOR_W'($urandom_range(hi, lo));
      end
    end else if (r < 80) begin
      s = $urandom_range(0, 1) ? '1 : '0;
      e = $urandom_range(0, 1) ? '1 : '0;
    end
  endtask

  // receiver: long runs of ready now and then, otherwise short bursts with stalls
  initial begin
    int unsigned run;
    int unsigned stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) < 2) ? $urandom_range(40, 200) : $urandom_range(1, 8);
      rsp_if.ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // hang detection: any moving word on either channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [FLOOR_W-1:0] s;
    logic [FLOOR_W-1:0] e;
    req_if.valid       = 1'b0;
    req_if.board_floor = '0;
    req_if.exit_floor  = '0;
    cfg_we             = 1'b0;
    cfg_idx            = REG_LOWEST;
    cfg_data           = '0;
    back_to_back       = 1'b0;
    tb_lowest          = '0;
    tb_highest         = '0;
    tb_count           = COUNT_W'(1);
    rst_n              = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset layout: one car serving floor 0 only
    push_request(8'd0, 8'd0);
    push_request(8'd0, 8'd1);
    push_request(8'd255, 8'd255);
    wait_drained();

    // mixed layout: car 0 everywhere, 1/2/7 share 10..20, car 3 empty,
    // car 4 only floor 0, car 5 only floor 255, car 6 50..150
    program_registers(64'h0A32_FF00_C80A_0A00, 64'h1496_FF00_6414_14FF, 64'd8);
    repeat (4) push_request(8'd15, 8'd12);
    push_request(8'd255, 8'd0);
    push_request(8'd255, 8'd255);
    push_request(8'd0, 8'd0);
    push_request(8'd0, 8'd255);
    push_request(8'd150, 8'd200);
    push_request(8'd100, 8'd100);
    push_request(8'd201, 8'd150);
    push_request(8'd20, 8'd10);
    wait_drained();

    // no cars in use: nothing can be found even with full ranges
    program_registers('0, '1, 64'd0);
    push_request(8'd0, 8'd255);
    push_request(8'd128, 8'd128);
    wait_drained();

    // count above the number of cars, clamps to all eight
    program_registers('0, '1, 64'd15);
    push_request(8'd0, 8'd0);
    push_request(8'd255, 8'd255);
    push_request(8'd7, 8'd200);
    push_request(8'd128, 8'd64);
    wait_drained();

    program_registers('0, '1, 64'd9);
    push_request(8'd1, 8'd254);
    push_request(8'd170, 8'd85);
    wait_drained();

    // random phases, each on a fresh layout written while idle
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      choose_layout();
      back_to_back = (phase % 4 == 2);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick_floors(s, e);
        push_request(s, e);
        if ($urandom_range(0, 59) == 0) wait_drained();
      end
      wait_drained();
    end

    // let anything stray show up before the verdict
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
